// ===== sv/tbplc_pkg.sv =====
// shared types, constants and helpers for the two-bit-per-byte link codec
package tbplc_pkg;

    localparam logic [7:0] LINE_IDLE = 8'h7F;
    localparam logic [7:0] LINE_DATA_MASK = 8'h24;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    // byte index within one transmit transaction, up to three characters of four bytes
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LAST_SHORT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LAST_LONG = 4'd11;

    typedef struct packed {
        logic       operation;
        logic [7:0] tx_char;
        logic       tx_end_of_command;
        logic [7:0] rx_raw;
    } t_in_item;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_tx_beat;

    typedef struct packed {
        logic       complete;
        logic [7:0] ch;
        logic       line_end;
    } t_rx_result;

    // one bit pair onto the idle line byte: low bit at bit 2, high bit at bit 5
    function automatic logic [7:0] encode_pair(input logic [1:0] pair);
        logic [7:0] b;
        b = LINE_IDLE & ~LINE_DATA_MASK;
        b[2] = pair[0];
        b[5] = pair[1];
        return b;
    endfunction

endpackage

// ===== sv/tbplc_in_if.sv =====
// input channel of the link codec
interface tbplc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] tx_char;
    logic       tx_end_of_command;
    logic [7:0] rx_raw;

    modport source (output valid, output operation, output tx_char,
                    output tx_end_of_command, output rx_raw, input ready);
    modport sink (input valid, input operation, input tx_char,
                  input tx_end_of_command, input rx_raw, output ready);
endinterface

// ===== sv/tbplc_out_if.sv =====
// result channel of the link codec
interface tbplc_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value;
    logic       line_end;
    logic       last;

    modport source (output valid, output kind, output value, output line_end,
                    output last, input ready);
    modport sink (input valid, input kind, input value, input line_end,
                  input last, output ready);
endinterface

// ===== sv/tbplc_tx_encoder.sv =====
// transmit byte generator: character, cr and lf spread over line bytes by step
module tbplc_tx_encoder (
    input  logic [7:0]                  i_char,
    input  logic                        i_eoc,
    input  logic [tbplc_pkg::STEP_W-1:0] i_step,
    output tbplc_pkg::t_tx_beat         o_beat
);
    import tbplc_pkg::*;

    logic [7:0] w_ch;
    logic [1:0] w_pair;

    always_comb begin
        unique case (i_step[3:2])
            2'd0:    w_ch = i_char;
            2'd1:    w_ch = CHAR_CR;
            default: w_ch = CHAR_LF;
        endcase
        unique case (i_step[1:0])
            2'd0:    w_pair = w_ch[1:0];
            2'd1:    w_pair = w_ch[3:2];
            2'd2:    w_pair = w_ch[5:4];
            default: w_pair = w_ch[7:6];
        endcase
        o_beat.value = encode_pair(w_pair);
        o_beat.last  = i_eoc ? (i_step == STEP_LAST_LONG) : (i_step == STEP_LAST_SHORT);
    end
endmodule

// ===== sv/tbplc_rx_decoder.sv =====
// receive side: gathers bit pairs into characters and tracks cr before lf
module tbplc_rx_decoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_raw,
    output tbplc_pkg::t_rx_result  o_result
);
    import tbplc_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [5:0] r_partial, n_partial;
    logic       r_prev_cr, n_prev_cr;
    logic [1:0] w_pair;

    always_comb begin
        w_pair    = {i_raw[5], i_raw[2]};
        n_phase   = r_phase;
        n_partial = r_partial;
        n_prev_cr = r_prev_cr;
        o_result.complete = (r_phase == 2'd3);
        o_result.ch       = {w_pair, r_partial};
        o_result.line_end = (o_result.ch == CHAR_LF) && r_prev_cr;
        if (i_fire) begin
            unique case (r_phase)
                2'd0: n_partial[1:0] = w_pair;
                2'd1: n_partial[3:2] = w_pair;
                2'd2: n_partial[5:4] = w_pair;
                default: begin
                    n_partial = '0;
                    n_prev_cr = (o_result.ch == CHAR_CR);
                end
            endcase
            n_phase = r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_partial <= '0;
            r_prev_cr <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_prev_cr <= n_prev_cr;
        end
    end
endmodule

// ===== sv/two_bit_per_byte_link_codec.sv =====
// top level of the two-bit-per-byte link codec
//
//  channel | direction | contents
//  i_in    | sink      | operation, tx_char, tx_end_of_command, rx_raw
//  o_out   | source    | kind, value, line_end, last
//
// a transmit transaction gives 4 line bytes, or 12 with the cr/lf terminator,
// one per cycle out of the byte sequencer while o_out is not stalled; a receive
// transaction takes one raw byte and gives a character on every fourth raw byte
// the path runs through the input register, then the result register
// reset (i_rst_n, synchronous, active low) empties both registers and clears
// the receive phase, partial bits and the cr flag
// a stalled o_out holds the result register; i_in stays ready while the input
// register is empty or its transaction finishes this cycle
module two_bit_per_byte_link_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbplc_in_if.sink    i_in,
    tbplc_out_if.source o_out
);
    import tbplc_pkg::*;

    // input register
    logic        r_item_valid;
    t_in_item    r_item;
    // byte index of the transmit transaction in the input register
    logic [STEP_W-1:0] r_step;
    // result register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_out_value;
    logic        r_out_line_end;
    logic        r_out_last;

    logic        w_is_rx;
    logic        w_out_free;
    logic        w_work;
    logic        w_item_done;
    logic        w_load_out;
    logic        w_in_fire;
    t_tx_beat    w_tx_beat;
    t_rx_result  w_rx_result;

    tbplc_tx_encoder u_tx (
        .i_char (r_item.tx_char),
        .i_eoc  (r_item.tx_end_of_command),
        .i_step (r_step),
        .o_beat (w_tx_beat)
    );

    tbplc_rx_decoder u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_work && w_is_rx),
        .i_raw    (r_item.rx_raw),
        .o_result (w_rx_result)
    );

    always_comb begin
        w_is_rx     = (r_item.operation == OP_DECODE);
        // the result register can take a new entry this cycle
        w_out_free  = !r_out_valid || o_out.ready;
        w_work      = r_item_valid && w_out_free;
        // receive transactions finish in one step, transmit at their last byte
        w_item_done = w_is_rx || w_tx_beat.last;
        w_load_out  = w_work && (!w_is_rx || w_rx_result.complete);
        i_in.ready  = !r_item_valid || (w_work && w_item_done);
        w_in_fire   = i_in.valid && i_in.ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
        end else begin
            if (w_in_fire) begin
                r_item_valid <= 1'b1;
            end else if (w_work && w_item_done) begin
                r_item_valid <= 1'b0;
            end
            if (w_work) begin
                r_step <= w_item_done ? '0 : r_step + {{(STEP_W-1){1'b0}}, 1'b1};
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item.operation         <= i_in.operation;
            r_item.tx_char           <= i_in.tx_char;
            r_item.tx_end_of_command <= i_in.tx_end_of_command;
            r_item.rx_raw            <= i_in.rx_raw;
        end
        if (w_load_out) begin
            if (w_is_rx) begin
                r_out_kind     <= KIND_CHAR;
                r_out_value    <= w_rx_result.ch;
                r_out_line_end <= w_rx_result.line_end;
                r_out_last     <= 1'b1;
            end else begin
                r_out_kind     <= KIND_LINE;
                r_out_value    <= w_tx_beat.value;
                r_out_line_end <= 1'b0;
                r_out_last     <= w_tx_beat.last;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.value    = r_out_value;
    assign o_out.line_end = r_out_line_end;
    assign o_out.last     = r_out_last;
endmodule
